// ----- hw/rtl/i2cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Item types, operation codes and phase tables shared by the engine modules.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned UNITS_W = 3;
  localparam int unsigned BIT_W   = 3;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = 16'd500;

  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;
  localparam logic [OP_W-1:0] OP_ACK   = 3'd5;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
  } out_item_t;

  // Number of delay units spent in each phase of each operation.
  function automatic logic [UNITS_W-1:0] phase_units(input logic [OP_W-1:0] op,
                                                      input logic [PHASE_W-1:0] ph);
    logic [UNITS_W-1:0] u;
    u = 3'd2;
    case (op)
      OP_START: begin
        case (ph)
          3'd0:    u = 3'd1;
          3'd1:    u = 3'd5;
          3'd2:    u = 3'd5;
          default: u = 3'd2;
        endcase
      end
      OP_STOP: begin
        case (ph)
          3'd0:    u = 3'd1;
          3'd1:    u = 3'd5;
          default: u = 3'd4;
        endcase
      end
      OP_WRITE: begin
        case (ph)
          3'd0:    u = 3'd1;
          3'd1:    u = 3'd5;
          3'd4:    u = 3'd3;
          default: u = 3'd2;
        endcase
      end
      OP_READ: begin
        case (ph)
          3'd0:    u = 3'd1;
          3'd1:    u = 3'd5;
          default: u = 3'd2;
        endcase
      end
      default: begin
        case (ph)
          3'd0:    u = 3'd3;
          3'd1:    u = 3'd5;
          default: u = 3'd2;
        endcase
      end
    endcase
    return u;
  endfunction

  // Index of the final phase of each operation.
  function automatic logic [PHASE_W-1:0] last_phase(input logic [OP_W-1:0] op);
    logic [PHASE_W-1:0] p;
    case (op)
      OP_START: p = 3'd3;
      OP_WRITE: p = 3'd5;
      OP_READ:  p = 3'd4;
      default:  p = 3'd2;
    endcase
    return p;
  endfunction

endpackage

// ----- hw/rtl/i2cbe_core.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine core
// Holds the bus sequencing state and advances it by one tick per enabled step.
// ----------------------------------------------------------------------------
module i2cbe_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  i2cbe_pkg::in_item_t       item,
  input  logic [i2cbe_pkg::UNIT_W-1:0] unit_ticks,
  output i2cbe_pkg::out_item_t      res
);

  logic [i2cbe_pkg::OP_W-1:0]    cur_op_r, cur_op_nxt;
  logic [i2cbe_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [i2cbe_pkg::UNIT_W-1:0]  tick_r, tick_nxt;
  logic [i2cbe_pkg::UNITS_W-1:0] units_r, units_nxt;
  logic [i2cbe_pkg::BIT_W-1:0]   bit_r, bit_nxt;
  logic [7:0]                    shift_r, shift_nxt;
  logic                          scl_r, scl_nxt;
  logic                          sda_r, sda_nxt;
  logic                          ack_r, ack_nxt;
  logic [7:0]                    rx_r, rx_nxt;
  logic                          done;
  logic                          op_acc;
  logic [i2cbe_pkg::UNIT_W-1:0]  unit_len;

  assign unit_len = (unit_ticks == '0) ? 16'd1 : unit_ticks;

  always_comb begin
    op_acc     = (cur_op_r == i2cbe_pkg::OP_NONE) &&
                 (item.operation inside {[i2cbe_pkg::OP_START:i2cbe_pkg::OP_ACK]});
    cur_op_nxt = cur_op_r;
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    units_nxt  = units_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    ack_nxt    = ack_r;
    rx_nxt     = rx_r;
    done       = 1'b0;

    if (op_acc) begin
      cur_op_nxt = item.operation;
      phase_nxt  = '0;
      bit_nxt    = '0;
      units_nxt  = '0;
      case (item.operation)
        i2cbe_pkg::OP_WRITE: shift_nxt = item.tx_byte;
        i2cbe_pkg::OP_READ:  shift_nxt = '0;
        i2cbe_pkg::OP_ACK:   shift_nxt = {7'd0, item.ack_level};
        default: ;
      endcase
    end

    if (cur_op_nxt != i2cbe_pkg::OP_NONE) begin
      if (units_nxt == '0) begin
        case (cur_op_nxt)
          i2cbe_pkg::OP_START: begin
            case (phase_nxt)
              3'd0:    sda_nxt = 1'b1;
              3'd1:    scl_nxt = 1'b1;
              3'd2:    sda_nxt = 1'b0;
              default: scl_nxt = 1'b0;
            endcase
          end
          i2cbe_pkg::OP_STOP: begin
            case (phase_nxt)
              3'd0:    sda_nxt = 1'b0;
              3'd1:    scl_nxt = 1'b1;
              default: sda_nxt = 1'b1;
            endcase
          end
          i2cbe_pkg::OP_WRITE: begin
            case (phase_nxt)
              3'd0: begin
                if (bit_nxt != '0) begin
                  scl_nxt = 1'b0;
                end
                sda_nxt = shift_nxt[3'd7 - bit_nxt];
              end
              3'd1:    scl_nxt = 1'b1;
              3'd2:    scl_nxt = 1'b0;
              3'd3:    sda_nxt = 1'b1;
              3'd4:    scl_nxt = 1'b1;
              default: begin
                ack_nxt = ~item.sda_in;
                scl_nxt = 1'b0;
              end
            endcase
          end
          i2cbe_pkg::OP_READ: begin
            case (phase_nxt)
              3'd0:    sda_nxt = 1'b1;
              3'd1:    scl_nxt = 1'b0;
              3'd2:    scl_nxt = 1'b1;
              3'd3:    shift_nxt = {shift_nxt[6:0], item.sda_in};
              default: scl_nxt = 1'b0;
            endcase
          end
          default: begin
            case (phase_nxt)
              3'd0:    sda_nxt = shift_nxt[0];
              3'd1:    scl_nxt = 1'b1;
              default: scl_nxt = 1'b0;
            endcase
          end
        endcase
        units_nxt = i2cbe_pkg::phase_units(cur_op_nxt, phase_nxt);
        tick_nxt  = unit_len;
      end

      tick_nxt = tick_nxt - 16'd1;
      if (tick_nxt == '0) begin
        units_nxt = units_nxt - 3'd1;
        if (units_nxt == '0) begin
          if (((cur_op_nxt == i2cbe_pkg::OP_WRITE) && (phase_nxt == 3'd1) ||
               (cur_op_nxt == i2cbe_pkg::OP_READ) && (phase_nxt == 3'd3)) &&
              (bit_nxt != 3'd7)) begin
            bit_nxt   = bit_nxt + 3'd1;
            phase_nxt = '0;
          end else if (phase_nxt >= i2cbe_pkg::last_phase(cur_op_nxt)) begin
            if (cur_op_nxt == i2cbe_pkg::OP_READ) begin
              rx_nxt = shift_nxt;
            end
            cur_op_nxt = i2cbe_pkg::OP_NONE;
            phase_nxt  = '0;
            bit_nxt    = '0;
            done       = 1'b1;
          end else begin
            phase_nxt = phase_nxt + 3'd1;
          end
        end else begin
          tick_nxt = unit_len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_op_r <= i2cbe_pkg::OP_NONE;
      phase_r  <= '0;
      tick_r   <= '0;
      units_r  <= '0;
      bit_r    <= '0;
      shift_r  <= '0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      ack_r    <= 1'b0;
      rx_r     <= '0;
    end else if (step_en) begin
      cur_op_r <= cur_op_nxt;
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      units_r  <= units_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      ack_r    <= ack_nxt;
      rx_r     <= rx_nxt;
    end
  end

  always_comb begin
    res.scl_out      = scl_nxt;
    res.sda_out      = sda_nxt;
    res.busy_res     = (cur_op_nxt != i2cbe_pkg::OP_NONE);
    res.done_res     = done;
    res.rx_byte      = rx_nxt;
    res.ack_received = ack_nxt;
  end

  // When idle, the sequencing counters are all back at zero.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_op_r == i2cbe_pkg::OP_NONE) |-> (phase_r == '0) && (bit_r == '0) && (units_r == '0))
    else $error("sequencing counters not cleared while idle");

  // A busy engine never holds more units than the longest phase.
  a_units_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_op_r != i2cbe_pkg::OP_NONE) |-> (units_r <= 3'd5))
    else $error("unit count out of range while busy");

  // The phase never runs past the final phase of the operation.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_op_r != i2cbe_pkg::OP_NONE) |-> (phase_r <= i2cbe_pkg::last_phase(cur_op_r)))
    else $error("phase beyond final phase");

  // A step that completes an operation leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && done) |=> (cur_op_r == i2cbe_pkg::OP_NONE))
    else $error("engine still busy after completion");

endmodule

// ----- hw/rtl/i2c_master_bit_engine.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine
// Tick-driven I2C master that generates start, stop, byte and ack sequences.
// ----------------------------------------------------------------------------
// Each input item is one timing tick and produces exactly one result item,
// which carries the SCL and SDA drive levels, busy, a completion pulse, the
// last received byte and the acknowledge flag. The engine takes one item per
// clock cycle while the output is not stalled; an item is held in an input
// register, applied to the bus sequencing state in a single pass and its
// result lands in the output register, from which it is offered. The input
// and output registers are the only buffers, so a stalled output holds the
// next item in the input register. The delay unit register is written through
// cfg_wr_en and cfg_wr_data and resets to 500 ticks.
module i2c_master_bit_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  i2cbe_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output i2cbe_pkg::out_item_t         out_data,
  input  logic                         cfg_wr_en,
  input  logic [i2cbe_pkg::UNIT_W-1:0] cfg_wr_data
);

  logic                          in_vld_r;
  i2cbe_pkg::in_item_t           in_item_r;
  logic                          out_vld_r;
  i2cbe_pkg::out_item_t          out_data_r;
  logic [i2cbe_pkg::UNIT_W-1:0]  unit_ticks_r;
  logic                          step_en;
  i2cbe_pkg::out_item_t          step_res;

  assign step_en  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && out_vld_r && out_stall;

  i2cbe_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .item       (in_item_r),
    .unit_ticks (unit_ticks_r),
    .res        (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= i2cbe_pkg::UNIT_TICKS_RST;
    end else if (cfg_wr_en) begin
      unit_ticks_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (step_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_en) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ----- verif/i2c_master_bit_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives one tick item at a time into the engine with random gaps on the input
// side and random stalls on the result side. A tracker inside the bench works
// out the expected SCL, SDA, busy, done, received byte and acknowledge flag for
// every tick and checks each result against them. The delay unit starts at its
// reset value and is changed during the run, once mid-phase, and also to zero.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;

  typedef logic [i2cbe_pkg::OP_W-1:0] op_code_t;

  localparam op_code_t OP_SPARE6 = 3'd6;
  localparam op_code_t OP_SPARE7 = 3'd7;

  class bus_level_tracker;
    logic [i2cbe_pkg::UNIT_W-1:0] unit_ticks;
    op_code_t                     cur_op;
    logic [2:0]                   phase;
    logic [15:0]                  tick_cnt;
    logic [2:0]                   units_left;
    logic [3:0]                   bit_idx;
    logic [7:0]                   shifter;
    logic [7:0]                   rx_hold;
    logic                         scl;
    logic                         sda;
    logic                         ack_flag;
    i2cbe_pkg::out_item_t         pending_levels[$];
    int                           mismatch_count;
    int                           op_count[8];
    int                           done_count;
    int                           tick_total;

    function new();
      unit_ticks = i2cbe_pkg::UNIT_TICKS_RST;
      cur_op = i2cbe_pkg::OP_NONE;
      phase = '0;
      tick_cnt = '0;
      units_left = '0;
      bit_idx = '0;
      shifter = '0;
      rx_hold = '0;
      scl = 1'b1;
      sda = 1'b1;
      ack_flag = 1'b0;
      mismatch_count = 0;
      done_count = 0;
      tick_total = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function logic [15:0] unit_len();
      return (unit_ticks == '0) ? 16'd1 : unit_ticks;
    endfunction

    function logic [2:0] enter_phase(logic sda_in);
      logic [2:0] u;
      u = 3'd2;
      case (cur_op)
        i2cbe_pkg::OP_START: begin
          case (phase)
            3'd0: begin sda = 1'b1; u = 3'd1; end
            3'd1: begin scl = 1'b1; u = 3'd5; end
            3'd2: begin sda = 1'b0; u = 3'd5; end
            default: scl = 1'b0;
          endcase
        end
        i2cbe_pkg::OP_STOP: begin
          case (phase)
            3'd0: begin sda = 1'b0; u = 3'd1; end
            3'd1: begin scl = 1'b1; u = 3'd5; end
            default: begin sda = 1'b1; u = 3'd4; end
          endcase
        end
        i2cbe_pkg::OP_WRITE: begin
          case (phase)
            3'd0: begin
              if (bit_idx != 4'd0) scl = 1'b0;
              sda = shifter[3'd7 - bit_idx[2:0]];
              u = 3'd1;
            end
            3'd1: begin scl = 1'b1; u = 3'd5; end
            3'd2: scl = 1'b0;
            3'd3: sda = 1'b1;
            3'd4: begin scl = 1'b1; u = 3'd3; end
            default: begin ack_flag = ~sda_in; scl = 1'b0; end
          endcase
        end
        i2cbe_pkg::OP_READ: begin
          case (phase)
            3'd0: begin sda = 1'b1; u = 3'd1; end
            3'd1: begin scl = 1'b0; u = 3'd5; end
            3'd2: scl = 1'b1;
            3'd3: shifter = {shifter[6:0], sda_in};
            default: scl = 1'b0;
          endcase
        end
        default: begin
          case (phase)
            3'd0: begin sda = shifter[0]; u = 3'd3; end
            3'd1: begin scl = 1'b1; u = 3'd5; end
            default: scl = 1'b0;
          endcase
        end
      endcase
      return u;
    endfunction

    // Returns 1 when the operation has run its final phase.
    function logic advance_phase();
      logic [2:0] last;
      if ((cur_op == i2cbe_pkg::OP_WRITE && phase == 3'd1 ||
           cur_op == i2cbe_pkg::OP_READ && phase == 3'd3) && bit_idx < 4'd7) begin
        bit_idx++;
        phase = '0;
        return 1'b0;
      end
      case (cur_op)
        i2cbe_pkg::OP_START: last = 3'd3;
        i2cbe_pkg::OP_WRITE: last = 3'd5;
        i2cbe_pkg::OP_READ:  last = 3'd4;
        default:             last = 3'd2;
      endcase
      if (phase >= last) begin
        if (cur_op == i2cbe_pkg::OP_READ) rx_hold = shifter;
        return 1'b1;
      end
      phase++;
      return 1'b0;
    endfunction

    function void note_tick(i2cbe_pkg::in_item_t it);
      i2cbe_pkg::out_item_t r;
      logic                 done;
      done = 1'b0;
      tick_total++;
      if (cur_op == i2cbe_pkg::OP_NONE && it.operation >= i2cbe_pkg::OP_START &&
          it.operation <= i2cbe_pkg::OP_ACK) begin
        cur_op = it.operation;
        phase = '0;
        bit_idx = '0;
        units_left = '0;
        op_count[it.operation]++;
        if (it.operation == i2cbe_pkg::OP_WRITE) shifter = it.tx_byte;
        else if (it.operation == i2cbe_pkg::OP_READ) shifter = '0;
        else if (it.operation == i2cbe_pkg::OP_ACK) shifter = {7'd0, it.ack_level};
      end
      if (cur_op != i2cbe_pkg::OP_NONE) begin
        if (units_left == '0) begin
          units_left = enter_phase(it.sda_in);
          tick_cnt = unit_len();
        end
        tick_cnt--;
        if (tick_cnt == '0) begin
          units_left--;
          if (units_left == '0) begin
            if (advance_phase()) begin
              cur_op = i2cbe_pkg::OP_NONE;
              phase = '0;
              bit_idx = '0;
              done = 1'b1;
              done_count++;
            end
          end else begin
            tick_cnt = unit_len();
          end
        end
      end
      r.scl_out = scl;
      r.sda_out = sda;
      r.busy_res = (cur_op != i2cbe_pkg::OP_NONE);
      r.done_res = done;
      r.rx_byte = rx_hold;
      r.ack_received = ack_flag;
      pending_levels.push_back(r);
    endfunction

    function void check_result(i2cbe_pkg::out_item_t got);
      i2cbe_pkg::out_item_t want;
      if (pending_levels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: scl %b sda %b busy %b done %b rx %h ack %b",
                   got.scl_out, got.sda_out, got.busy_res, got.done_res, got.rx_byte,
                   got.ack_received);
        return;
      end
      want = pending_levels.pop_front();
      if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
          got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
          got.rx_byte !== want.rx_byte || got.ack_received !== want.ack_received) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Mismatch at %0t: expected scl %b sda %b busy %b done %b rx %h ack %b, %s",
                   $realtime, want.scl_out, want.sda_out, want.busy_res, want.done_res,
                   want.rx_byte, want.ack_received,
                   $sformatf("got scl %b sda %b busy %b done %b rx %h ack %b",
                             got.scl_out, got.sda_out, got.busy_res, got.done_res,
                             got.rx_byte, got.ack_received));
      end
    endfunction

    function logic busy();
      return cur_op != i2cbe_pkg::OP_NONE;
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  i2cbe_pkg::in_item_t          in_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  i2cbe_pkg::out_item_t         out_data;
  logic                         cfg_wr_en = 1'b0;
  logic [i2cbe_pkg::UNIT_W-1:0] cfg_wr_data = '0;

  bus_level_tracker             sb = new();
  bit                           idle_on = 1'b0;
  int                           settings_used = 0;
  logic [i2cbe_pkg::UNIT_W-1:0] unit_plan[5] = '{16'd1, 16'd3, 16'd0, 16'd2, 16'd4};

  i2c_master_bit_engine dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Results are taken at the falling edge before the rising edge that accepts them.
  initial begin
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      n = idle_on ? $urandom_range(0, 15) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
      while (!(rst_n && out_valid)) @(negedge clk);
    end
  end

  task automatic send_tick(i2cbe_pkg::in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    sb.note_tick(it);
  endtask

  function automatic logic sda_level_for(int mode);
    return (mode == 2) ? logic'($urandom_range(0, 1)) : logic'(mode);
  endfunction

  task automatic drive_tick(op_code_t op, logic [7:0] txb, logic ackl, logic sda_bit);
    i2cbe_pkg::in_item_t it;
    it.operation = op;
    it.tx_byte = txb;
    it.ack_level = ackl;
    it.sda_in = sda_bit;
    send_tick(it);
  endtask

  // Issues one operation and keeps ticking until it completes; operations
  // offered while the engine is busy must be ignored.
  task automatic run_op(op_code_t op, logic [7:0] txb, logic ackl, int sda_mode);
    op_code_t filler;
    drive_tick(op, txb, ackl, sda_level_for(sda_mode));
    while (sb.busy()) begin
      filler = ($urandom_range(0, 3) == 0) ? op_code_t'($urandom_range(0, 7))
                                           : i2cbe_pkg::OP_NONE;
      drive_tick(filler, 8'($urandom), 1'($urandom), sda_level_for(sda_mode));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_unit(logic [i2cbe_pkg::UNIT_W-1:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.unit_ticks = v;
    settings_used++;
  endtask

  initial begin
    int base;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A start under the reset delay unit, with a smaller unit written mid-phase.
    drive_tick(i2cbe_pkg::OP_START, 8'h00, 1'b0, 1'b1);
    repeat (20) drive_tick(i2cbe_pkg::OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
    write_unit(16'd1);
    while (sb.busy()) drive_tick(i2cbe_pkg::OP_NONE, 8'h00, 1'b0, 1'b1);

    idle_on = 1'b1;
    run_op(i2cbe_pkg::OP_STOP, 8'h00, 1'b0, 1);
    run_op(i2cbe_pkg::OP_START, 8'h00, 1'b0, 1);
    run_op(i2cbe_pkg::OP_WRITE, 8'hFF, 1'b0, 0);
    run_op(i2cbe_pkg::OP_WRITE, 8'h00, 1'b1, 1);
    run_op(i2cbe_pkg::OP_WRITE, 8'hA5, 1'b0, 2);
    run_op(i2cbe_pkg::OP_READ, 8'h00, 1'b0, 1);
    run_op(i2cbe_pkg::OP_READ, 8'hFF, 1'b1, 0);
    run_op(i2cbe_pkg::OP_READ, 8'h5A, 1'b0, 2);
    run_op(i2cbe_pkg::OP_ACK, 8'hFF, 1'b0, 0);
    run_op(i2cbe_pkg::OP_ACK, 8'h00, 1'b1, 1);
    drive_tick(OP_SPARE6, 8'hFF, 1'b1, 1'b1);
    drive_tick(OP_SPARE7, 8'h00, 1'b0, 1'b0);
    drive_tick(i2cbe_pkg::OP_NONE, 8'hFF, 1'b1, 1'b0);
    run_op(i2cbe_pkg::OP_STOP, 8'h00, 1'b0, 2);

    write_unit(16'd0);
    run_op(i2cbe_pkg::OP_START, 8'h00, 1'b0, 2);
    run_op(i2cbe_pkg::OP_WRITE, 8'h3C, 1'b0, 2);

    foreach (unit_plan[k]) begin
      write_unit(unit_plan[k]);
      base = sb.tick_total;
      while (sb.tick_total - base < 40) begin
        idle_on = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 7) == 0)
          drive_tick(op_code_t'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                     1'($urandom));
        else
          run_op(op_code_t'($urandom_range(i2cbe_pkg::OP_START, i2cbe_pkg::OP_ACK)),
                 8'($urandom), 1'($urandom), $urandom_range(0, 2));
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d ticks over %0d delay settings with %0d completed operations.",
             sb.tick_total, settings_used, sb.done_count);
    $display("Started: %0d start, %0d stop, %0d write, %0d read, %0d ack; %0d mismatches.",
             sb.op_count[i2cbe_pkg::OP_START], sb.op_count[i2cbe_pkg::OP_STOP],
             sb.op_count[i2cbe_pkg::OP_WRITE], sb.op_count[i2cbe_pkg::OP_READ],
             sb.op_count[i2cbe_pkg::OP_ACK], sb.mismatch_count);
    if (sb.mismatch_count == 0 && sb.pending_levels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/i2cbe_pkg.sv
hw/rtl/i2cbe_core.sv
hw/rtl/i2c_master_bit_engine.sv
verif/i2c_master_bit_engine_tb.sv
